// File: design/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, switched off while dis is high
`define ASSERT_CLK(lbl, clk, dis, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (dis) prop) else $error(msg);

// clocked property, switched off while an active-low reset is asserted
`define ASSERT_RST_N(lbl, clk, rst_n, prop, msg) \
    `ASSERT_CLK(lbl, clk, !(rst_n), prop, msg)

`endif

// File: design/nqbs_pkg.sv
package nqbs_pkg;

    // largest board the stack and masks are built for
    localparam int MAX_SIZE     = 16;
    // at most this many result words per search
    localparam int RESULT_LIMIT = 16;
    localparam int SIZE_LIMIT   = (MAX_SIZE < RESULT_LIMIT) ? MAX_SIZE : RESULT_LIMIT;

    // fixed field widths
    localparam int SIZE_W = 5;
    localparam int COL_W  = 4;
    localparam int ROW_W  = 4;

    // derived internal widths
    localparam int CNT_W  = $clog2(SIZE_LIMIT + 1);
    localparam int IDX_W  = $clog2(SIZE_LIMIT);
    localparam int DIAG_N = 2 * SIZE_LIMIT - 1;
    localparam int DIAG_W = $clog2(DIAG_N);

    typedef logic [SIZE_W-1:0] t_size;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [DIAG_W-1:0] t_diag;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic place;
        logic next_row;
        logic pop_rd;
        logic pop_fix;
        logic out_rd;
        logic out_adv;
        logic emit_sol;
        logic emit_none;
    } t_dp_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic size_bad;
        logic col_done;
        logic row_end;
        logic fits;
        logic col_zero;
        logic out_last;
    } t_dp_stat;

    // diagonal running one way: row + col
    function automatic t_diag diag_sum(t_idx row, t_idx col);
        return DIAG_W'(row) + DIAG_W'(col);
    endfunction

    // diagonal running the other way: row - col, offset to stay positive
    function automatic t_diag diag_dif(t_idx row, t_idx col);
        return DIAG_W'(row) + DIAG_W'(SIZE_LIMIT - 1) - DIAG_W'(col);
    endfunction

endpackage

// File: design/n_queens_backtrack_solver.sv
// N-queens first-solution solver. Pulse start with a board size while busy is low;
// the block searches depth first, one queen per column, rows tried in ascending
// order, and reports the first placement as one word per column (o_column,
// o_queen_row, o_found high, o_last on the final column), each word read from the
// row stack in S_OUT_RD and then emitted from S_OUT_WR. Sizes 2 and 3, zero, and
// sizes above 16 give a single word with o_found low and o_last high. Words appear
// for exactly one cycle on o_strobe and cannot be held off, so the receiver must
// take every strobed word. Search time is set by the row-test loop: one candidate
// row per cycle while scanning, with each backtrack step going through the
// row-stack memory port (a read in S_SCAN, then the mask fix in S_POP). A rejected
// size is answered in the cycle after start. busy stays high until the last word
// has been launched, and the next size may be given as soon as busy falls.
module n_queens_backtrack_solver (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [nqbs_pkg::SIZE_W-1:0] i_board_size,
    output logic                        o_strobe,
    output logic                        o_found,
    output logic [nqbs_pkg::COL_W-1:0]  o_column,
    output logic [nqbs_pkg::ROW_W-1:0]  o_queen_row,
    output logic                        o_last
);
    import nqbs_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // search sequencer
    nqbs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd),
        .o_busy  (busy)
    );

    // row stack, masks and result registers
    nqbs_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_board_size (i_board_size),
        .i_cmd        (dp_cmd),
        .o_stat       (dp_stat),
        .o_strobe     (o_strobe),
        .o_found      (o_found),
        .o_column     (o_column),
        .o_queen_row  (o_queen_row),
        .o_last       (o_last)
    );

endmodule

// File: design/nqbs_dp.sv
module nqbs_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  nqbs_pkg::t_size             i_board_size,
    input  nqbs_pkg::t_dp_cmd           i_cmd,
    output nqbs_pkg::t_dp_stat          o_stat,
    output logic                        o_strobe,
    output logic                        o_found,
    output logic [nqbs_pkg::COL_W-1:0]  o_column,
    output logic [nqbs_pkg::ROW_W-1:0]  o_queen_row,
    output logic                        o_last
);
    import nqbs_pkg::*;

    // search registers
    t_cnt r_size;
    t_cnt r_col;
    t_cnt r_row;
    t_cnt r_out_idx;

    // occupancy masks for rows and both diagonals
    logic [SIZE_LIMIT-1:0] r_row_used;
    logic [DIAG_N-1:0]     r_diag_s;
    logic [DIAG_N-1:0]     r_diag_d;

    // row stack, one entry per column
    t_idx r_stack [SIZE_LIMIT];
    t_idx r_rd_data;

    // result word registers
    logic             r_strobe;
    logic             r_found;
    logic [COL_W-1:0] r_column;
    logic [ROW_W-1:0] r_queen_row;
    logic             r_last;

    t_idx  col_idx;
    t_idx  row_idx;
    t_cnt  pop_col;
    t_idx  rd_addr;
    t_diag place_ds;
    t_diag place_dd;
    t_diag pop_ds;
    t_diag pop_dd;

    // index and diagonal decode
    always_comb begin
        col_idx  = r_col[IDX_W-1:0];
        row_idx  = r_row[IDX_W-1:0];
        pop_col  = r_col - CNT_W'(1);
        rd_addr  = i_cmd.pop_rd ? pop_col[IDX_W-1:0] : r_out_idx[IDX_W-1:0];
        place_ds = diag_sum(row_idx, col_idx);
        place_dd = diag_dif(row_idx, col_idx);
        pop_ds   = diag_sum(r_rd_data, col_idx);
        pop_dd   = diag_dif(r_rd_data, col_idx);
    end

    // status back to the controller
    always_comb begin
        o_stat.size_bad = (i_board_size == '0) || (i_board_size > SIZE_W'(SIZE_LIMIT));
        o_stat.col_done = (r_col == r_size);
        o_stat.row_end  = (r_row >= r_size);
        o_stat.fits     = !r_row_used[row_idx] && !r_diag_s[place_ds] && !r_diag_d[place_dd];
        o_stat.col_zero = (r_col == '0);
        o_stat.out_last = (r_out_idx == r_size - CNT_W'(1));
    end

    // column, row and output counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size    <= '0;
            r_col     <= '0;
            r_row     <= '0;
            r_out_idx <= '0;
        end else begin
            if (i_cmd.load) begin
                r_size    <= CNT_W'(i_board_size);
                r_col     <= '0;
                r_row     <= '0;
                r_out_idx <= '0;
            end
            if (i_cmd.place) begin
                r_col <= r_col + CNT_W'(1);
                r_row <= '0;
            end
            if (i_cmd.next_row) begin
                r_row <= r_row + CNT_W'(1);
            end
            if (i_cmd.pop_rd) begin
                r_col <= pop_col;
            end
            if (i_cmd.pop_fix) begin
                r_row <= CNT_W'(r_rd_data) + CNT_W'(1);
            end
            if (i_cmd.out_adv) begin
                r_out_idx <= r_out_idx + CNT_W'(1);
            end
        end
    end

    // masks: cleared per search, set on place, cleared on backtrack
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_row_used <= '0;
            r_diag_s   <= '0;
            r_diag_d   <= '0;
        end else if (i_cmd.place) begin
            r_row_used[row_idx] <= 1'b1;
            r_diag_s[place_ds]  <= 1'b1;
            r_diag_d[place_dd]  <= 1'b1;
        end else if (i_cmd.pop_fix) begin
            r_row_used[r_rd_data] <= 1'b0;
            r_diag_s[pop_ds]      <= 1'b0;
            r_diag_d[pop_dd]      <= 1'b0;
        end
    end

    // row stack memory with registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.place) begin
            r_stack[col_idx] <= row_idx;
        end
        if (i_cmd.pop_rd || i_cmd.out_rd) begin
            r_rd_data <= r_stack[rd_addr];
        end
    end

    // result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit_sol || i_cmd.emit_none;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_sol) begin
            r_found     <= 1'b1;
            r_column    <= COL_W'(r_out_idx);
            r_queen_row <= ROW_W'(r_rd_data);
            r_last      <= o_stat.out_last;
        end else if (i_cmd.emit_none) begin
            r_found     <= 1'b0;
            r_column    <= '0;
            r_queen_row <= '0;
            r_last      <= 1'b1;
        end
    end

    assign o_strobe    = r_strobe;
    assign o_found     = r_found;
    assign o_column    = r_column;
    assign o_queen_row = r_queen_row;
    assign o_last      = r_last;

endmodule

// File: design/nqbs_ctrl.sv
module nqbs_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  nqbs_pkg::t_dp_stat i_stat,
    output nqbs_pkg::t_dp_cmd  o_cmd,
    output logic               o_busy
);
    import nqbs_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_POP    = 3'd2;
    localparam logic [2:0] S_OUT_RD = 3'd3;
    localparam logic [2:0] S_OUT_WR = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_stat.size_bad) begin
                        o_cmd.emit_none = 1'b1;
                    end else begin
                        o_cmd.load = 1'b1;
                        n_state    = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (i_stat.col_done) begin
                    n_state = S_OUT_RD;
                end else if (!i_stat.row_end) begin
                    if (i_stat.fits) begin
                        o_cmd.place = 1'b1;
                    end else begin
                        o_cmd.next_row = 1'b1;
                    end
                end else if (i_stat.col_zero) begin
                    o_cmd.emit_none = 1'b1;
                    n_state         = S_IDLE;
                end else begin
                    o_cmd.pop_rd = 1'b1;
                    n_state      = S_POP;
                end
            end
            S_POP: begin
                o_cmd.pop_fix = 1'b1;
                n_state       = S_SCAN;
            end
            S_OUT_RD: begin
                o_cmd.out_rd = 1'b1;
                n_state      = S_OUT_WR;
            end
            S_OUT_WR: begin
                o_cmd.emit_sol = 1'b1;
                if (i_stat.out_last) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.out_adv = 1'b1;
                    n_state       = S_OUT_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// File: design/nqbs_checker.sv
`include "assert_macros.svh"

module nqbs_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        o_strobe,
    input logic                        o_found,
    input logic [nqbs_pkg::COL_W-1:0]  o_column,
    input logic [nqbs_pkg::ROW_W-1:0]  o_queen_row,
    input logic                        o_last
);
    import nqbs_pkg::*;

    logic             accept;
    logic             none_word;
    logic             none_ok;
    logic             sol_mid;
    logic             next_col_ok;
    logic [COL_W-1:0] r_col_q1;
    logic [COL_W-1:0] r_col_q2;

    // handshake and word decode
    assign accept      = start && !busy;
    assign none_word   = o_strobe && !o_found;
    assign none_ok     = o_last && (o_column == '0) && (o_queen_row == '0) && !busy;
    assign sol_mid     = o_strobe && o_found && !o_last;
    assign next_col_ok = o_strobe && o_found && (o_column == COL_W'(r_col_q2 + COL_W'(1)));

    // column held back through two registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_q1 <= '0;
            r_col_q2 <= '0;
        end else begin
            r_col_q1 <= o_column;
            r_col_q2 <= r_col_q1;
        end
    end

    // an accepted size either starts a search or is rejected at once
    `ASSERT_RST_N(a_accept_reacts, i_clk, i_rst_n, accept |=> (busy || none_word), "size ignored")

    // a no-solution word is alone and empty
    `ASSERT_RST_N(a_none_word, i_clk, i_rst_n, none_word |-> none_ok, "malformed no-solution word")

    // no strobe directly follows a solution word that is not the last
    `ASSERT_RST_N(a_sol_gap, i_clk, i_rst_n, sol_mid |=> !o_strobe, "solution words too close")

    // the next solution word covers the next column
    `ASSERT_RST_N(a_sol_next_col, i_clk, i_rst_n, sol_mid |=> ##1 next_col_ok, "column order")

endmodule

bind n_queens_backtrack_solver nqbs_checker u_nqbs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_strobe    (o_strobe),
    .o_found     (o_found),
    .o_column    (o_column),
    .o_queen_row (o_queen_row),
    .o_last      (o_last)
);
